@@ rtl/rv64_exe_pkg.sv @@
// Shared types and constants of the RV64IM execute stage.
`default_nettype none
package rv64_exe_pkg;

    localparam int IN_BITS    = 280;
    localparam int OUT_BITS   = 168;
    localparam int STEP_BITS  = 6;

    typedef enum logic [4:0] {
        CMD_NOP   = 5'd0,  CMD_ADD   = 5'd1,  CMD_SUB  = 5'd2,  CMD_MUL  = 5'd3,
        CMD_MULH  = 5'd4,  CMD_DIV   = 5'd5,  CMD_REM  = 5'd6,  CMD_SLL  = 5'd7,
        CMD_SRL   = 5'd8,  CMD_SRA   = 5'd9,  CMD_SLT  = 5'd10, CMD_XOR  = 5'd11,
        CMD_OR    = 5'd12, CMD_AND   = 5'd13, CMD_ADDW = 5'd14, CMD_SUBW = 5'd15,
        CMD_MULW  = 5'd16, CMD_SLLW  = 5'd17, CMD_SRLW = 5'd18, CMD_SRAW = 5'd19,
        CMD_LOAD  = 5'd20, CMD_STORE = 5'd21, CMD_LUI  = 5'd22, CMD_AUIPC = 5'd23,
        CMD_JAL   = 5'd24, CMD_JALR  = 5'd25, CMD_BEQ  = 5'd26, CMD_BNE  = 5'd27,
        CMD_BLT   = 5'd28, CMD_BGE   = 5'd29, CMD_RSV0 = 5'd30, CMD_RSV1 = 5'd31
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_ITER, ST_FIX_LO, ST_FIX_HI, ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/rv64_execute_stage_with_forwarding.sv @@
// Top level of the RV64IM execute stage with two-deep result forwarding.
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+-----------------------------------
//  s_       | in        | s_tvalid/s_tready | s_tdata[279:0], one instruction
//  m_       | out       | m_tvalid/m_tready | m_tdata[167:0], one result
//
// A simple operation passes the execute and hand-off states before it reaches
// the output register; no new instruction is taken until the hand-off is done.
// Multiply, mulh, mulw, div and rem add 64 steps on one shared 65-bit adder and
// two sign fix-up steps, low half then high half, before the hand-off state
// registers the result. Division by zero and signed overflow skip the
// iterations and take the simple path.
// Reset is synchronous on aresetn low and clears the sequencer, the output
// valid and the forwarding window. s_tready is high only while the sequencer
// idles; a result waiting on m_tready holds the sequencer in its hand-off state.
`default_nettype none
module rv64_execute_stage_with_forwarding (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // cmd, rs_index, rt_index, dst_index, rs_value, rt_value, imm, pc,
    // use_imm, reg_write, mem_to_reg, load_data, then one zero pad bit.
    input  wire logic [rv64_exe_pkg::IN_BITS-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // alu_out, target_pc, redirect, store_data, dst_out, write_out, from_mem_out.
    output logic [rv64_exe_pkg::OUT_BITS-1:0]     m_tdata
);
    import rv64_exe_pkg::*;

    // Input field unpacking.
    logic [4:0]  in_cmd, in_rsi, in_rti, in_dst;
    logic [63:0] in_rs, in_rt, in_ld;
    logic [31:0] in_imm, in_pc;
    logic        in_use_imm, in_wr, in_fm;

    assign in_cmd     = s_tdata[4:0];
    assign in_rsi     = s_tdata[9:5];
    assign in_rti     = s_tdata[14:10];
    assign in_dst     = s_tdata[19:15];
    assign in_rs      = s_tdata[83:20];
    assign in_rt      = s_tdata[147:84];
    assign in_imm     = s_tdata[179:148];
    assign in_pc      = s_tdata[211:180];
    assign in_use_imm = s_tdata[212];
    assign in_wr      = s_tdata[213];
    assign in_fm      = s_tdata[214];
    assign in_ld      = s_tdata[278:215];

    // Forwarding window: the near slot is the previous instruction, the far
    // slot the one before it.
    logic [4:0]  near_dst_reg, far_dst_reg;
    logic        near_write_reg, near_from_mem_reg, far_write_reg, far_from_mem_reg;
    logic [63:0] near_value_reg, far_value_reg;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [63:0] a_reg, b_reg, rt_fwd_reg, imm64_reg, res_reg;
    logic [31:0] pc_reg, target_reg;
    logic        redirect_reg;
    logic [4:0]  dst_reg;
    logic        wr_reg, fm_reg, long_reg;
    logic [127:0] p_reg;
    logic [63:0] opb_reg;
    logic [STEP_BITS-1:0] cnt_reg;
    logic        neg_lo_reg, neg_hi_reg, carry_reg, is_mul_reg;
    logic        m_tvalid_reg;
    logic [OUT_BITS-1:0] m_tdata_reg;

    // Operand forwarding at acceptance; the far slot first, the near slot wins unless it is a load.
    logic [63:0] fwd_rs, fwd_rt, far_v;
    logic        far_ok, near_ok;
    always_comb begin
        far_v  = far_from_mem_reg ? in_ld : far_value_reg;
        far_ok = far_write_reg && (far_dst_reg != 5'd0);
        near_ok = near_write_reg && (near_dst_reg != 5'd0) && !near_from_mem_reg;
        fwd_rs = in_rs;
        fwd_rt = in_rt;
        if (far_ok && far_dst_reg == in_rsi) fwd_rs = far_v;
        if (far_ok && far_dst_reg == in_rti) fwd_rt = far_v;
        if (near_ok && near_dst_reg == in_rsi) fwd_rs = near_value_reg;
        if (near_ok && near_dst_reg == in_rti) fwd_rt = near_value_reg;
    end

    // Simple operations, evaluated in the execute state.
    logic [63:0] simple_res, sum_ab, dif_ab, upper_imm, a_mag, b_mag, link;
    logic [31:0] w_tmp, simple_target, br_target;
    logic        simple_redirect, lt_ab, is_long, div_special;
    logic [63:0] special_res;
    always_comb begin
        sum_ab    = a_reg + b_reg;
        dif_ab    = a_reg - b_reg;
        lt_ab     = $signed(a_reg) < $signed(b_reg);
        upper_imm = {{32{imm64_reg[19]}}, imm64_reg[19:0], 12'd0};
        link      = {32'd0, pc_reg} + 64'd4;
        br_target = pc_reg + imm64_reg[31:0];
        a_mag     = a_reg[63] ? (64'd0 - a_reg) : a_reg;
        b_mag     = b_reg[63] ? (64'd0 - b_reg) : b_reg;
        w_tmp     = 32'd0;
        simple_res      = 64'd0;
        simple_target   = pc_reg;
        simple_redirect = 1'b0;
        case (cmd_reg)
            CMD_ADD, CMD_LOAD, CMD_STORE: simple_res = sum_ab;
            CMD_SUB:  simple_res = dif_ab;
            CMD_SLL:  simple_res = a_reg << b_reg[5:0];
            CMD_SRL:  simple_res = a_reg >> b_reg[5:0];
            CMD_SRA:  simple_res = $unsigned($signed(a_reg) >>> b_reg[5:0]);
            CMD_SLT:  simple_res = {63'd0, lt_ab};
            CMD_XOR:  simple_res = a_reg ^ b_reg;
            CMD_OR:   simple_res = a_reg | b_reg;
            CMD_AND:  simple_res = a_reg & b_reg;
            CMD_ADDW: simple_res = {{32{sum_ab[31]}}, sum_ab[31:0]};
            CMD_SUBW: simple_res = {{32{dif_ab[31]}}, dif_ab[31:0]};
            CMD_SLLW: begin
                w_tmp = a_reg[31:0] << b_reg[4:0];
                simple_res = {{32{w_tmp[31]}}, w_tmp};
            end
            CMD_SRLW: begin
                w_tmp = a_reg[31:0] >> b_reg[4:0];
                simple_res = {{32{w_tmp[31]}}, w_tmp};
            end
            CMD_SRAW: begin
                w_tmp = $unsigned($signed(a_reg[31:0]) >>> b_reg[4:0]);
                simple_res = {{32{w_tmp[31]}}, w_tmp};
            end
            CMD_LUI:   simple_res = upper_imm;
            CMD_AUIPC: simple_res = {32'd0, pc_reg} + upper_imm;
            CMD_JAL: begin
                simple_res = link;
                simple_target = br_target;
                simple_redirect = 1'b1;
            end
            CMD_JALR: begin
                simple_res = link;
                w_tmp = a_reg[31:0] + imm64_reg[31:0];
                simple_target = {w_tmp[31:1], 1'b0};
                simple_redirect = 1'b1;
            end
            CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGE: begin
                simple_target = br_target;
                case (cmd_reg)
                    CMD_BEQ: simple_redirect = (a_reg == b_reg);
                    CMD_BNE: simple_redirect = (a_reg != b_reg);
                    CMD_BLT: simple_redirect = lt_ab;
                    default: simple_redirect = !lt_ab;
                endcase
            end
            default: simple_res = 64'd0;
        endcase
        is_long = cmd_reg inside {CMD_MUL, CMD_MULH, CMD_MULW, CMD_DIV, CMD_REM};
        // Division by zero and the most negative value divided by -1.
        div_special = (cmd_reg == CMD_DIV || cmd_reg == CMD_REM) &&
                      ((b_reg == 64'd0) ||
                       (a_reg == {1'b1, 63'd0} && b_reg == {64{1'b1}}));
        if (b_reg == 64'd0)
            special_res = (cmd_reg == CMD_REM) ? a_reg : {64{1'b1}};
        else
            special_res = (cmd_reg == CMD_REM) ? 64'd0 : a_reg;
    end

    // The shared 65-bit adder: multiply accumulate, divide trial subtract and
    // the two halves of the final negation.
    logic [64:0] add_x, add_y;
    logic        add_cin;
    logic [65:0] add_sum;
    always_comb begin
        add_x = 65'd0;
        add_y = 65'd0;
        add_cin = 1'b0;
        unique case (state_reg)
            ST_ITER: begin
                if (is_mul_reg) begin
                    add_x = {1'b0, p_reg[127:64]};
                    add_y = {1'b0, opb_reg};
                end else begin
                    add_x = {p_reg[127:64], p_reg[63]};
                    add_y = ~{1'b0, opb_reg};
                    add_cin = 1'b1;
                end
            end
            ST_FIX_LO: begin
                add_x = {1'b0, ~p_reg[63:0]};
                add_cin = 1'b1;
            end
            ST_FIX_HI: begin
                add_x = {1'b0, ~p_reg[127:64]};
                add_cin = is_mul_reg ? carry_reg : 1'b1;
            end
            default: add_cin = 1'b0;
        endcase
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {65'd0, add_cin};
    end

    // Next state.
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC:   state_next = (is_long && !div_special) ? ST_ITER : ST_DONE;
            ST_ITER:   if (cnt_reg == {STEP_BITS{1'b1}}) state_next = ST_FIX_LO;
            ST_FIX_LO: state_next = ST_FIX_HI;
            ST_FIX_HI: state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    logic in_take, out_load;
    always_comb begin
        in_take  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_take = s_tvalid;
            ST_DONE: out_load = out_free;
            default: out_load = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Final result selection once the iterations and fix-ups are over.
    logic [63:0] final_res;
    always_comb begin
        final_res = res_reg;
        if (long_reg) begin
            case (cmd_reg)
                CMD_MULH, CMD_REM: final_res = p_reg[127:64];
                CMD_MULW: final_res = {{32{p_reg[31]}}, p_reg[31:0]};
                default:  final_res = p_reg[63:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            near_dst_reg <= 5'd0; near_write_reg <= 1'b0;
            near_from_mem_reg <= 1'b0; near_value_reg <= 64'd0;
            far_dst_reg <= 5'd0; far_write_reg <= 1'b0;
            far_from_mem_reg <= 1'b0; far_value_reg <= 64'd0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (out_load) begin
                far_dst_reg <= near_dst_reg; far_write_reg <= near_write_reg;
                far_from_mem_reg <= near_from_mem_reg; far_value_reg <= near_value_reg;
                near_dst_reg <= dst_reg; near_write_reg <= wr_reg;
                near_from_mem_reg <= fm_reg; near_value_reg <= final_res;
            end
            if (state_reg == ST_ITER) cnt_reg <= cnt_reg + 1'b1;
            else cnt_reg <= '0;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg    <= cmd_t'(in_cmd);
            a_reg      <= fwd_rs;
            b_reg      <= in_use_imm ? {{32{in_imm[31]}}, in_imm} : fwd_rt;
            rt_fwd_reg <= fwd_rt;
            imm64_reg  <= {{32{in_imm[31]}}, in_imm};
            pc_reg     <= in_pc;
            dst_reg    <= in_dst;
            wr_reg     <= in_wr;
            fm_reg     <= in_fm;
        end
        if (state_reg == ST_EXEC) begin
            res_reg      <= div_special ? special_res : simple_res;
            target_reg   <= simple_target;
            redirect_reg <= simple_redirect;
            long_reg     <= is_long && !div_special;
            is_mul_reg   <= cmd_reg inside {CMD_MUL, CMD_MULH, CMD_MULW};
            case (cmd_reg)
                CMD_MUL: begin
                    p_reg <= {64'd0, a_reg};  opb_reg <= b_reg;
                    neg_lo_reg <= 1'b0; neg_hi_reg <= 1'b0;
                end
                CMD_MULW: begin
                    p_reg <= {96'd0, a_reg[31:0]};  opb_reg <= {32'd0, b_reg[31:0]};
                    neg_lo_reg <= 1'b0; neg_hi_reg <= 1'b0;
                end
                CMD_MULH: begin
                    p_reg <= {64'd0, a_mag};  opb_reg <= b_mag;
                    neg_lo_reg <= a_reg[63] ^ b_reg[63];
                    neg_hi_reg <= a_reg[63] ^ b_reg[63];
                end
                default: begin
                    // Divide: quotient builds in the low half, remainder high.
                    p_reg <= {64'd0, a_mag};  opb_reg <= b_mag;
                    neg_lo_reg <= a_reg[63] ^ b_reg[63];
                    neg_hi_reg <= a_reg[63];
                end
            endcase
        end
        if (state_reg == ST_ITER) begin
            if (is_mul_reg)
                p_reg <= p_reg[0] ? {add_sum[64:0], p_reg[63:1]} : {1'b0, p_reg[127:1]};
            else
                p_reg <= {add_sum[65] ? add_sum[63:0] : add_x[63:0],
                          p_reg[62:0], add_sum[65]};
        end
        if (state_reg == ST_FIX_LO) begin
            carry_reg <= add_sum[64];
            if (neg_lo_reg) p_reg[63:0] <= add_sum[63:0];
        end
        if (state_reg == ST_FIX_HI && neg_hi_reg) p_reg[127:64] <= add_sum[63:0];
        if (out_load)
            m_tdata_reg <= {fm_reg, wr_reg, dst_reg, rt_fwd_reg, redirect_reg,
                            target_reg, final_res};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_iter_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ITER && cnt_reg == {STEP_BITS{1'b1}}) |=> state_reg == ST_FIX_LO)
        else $error("iteration count overrun");
    a_out_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result shown outside hand-off");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && state_reg == ST_IDLE) else $error("reset not applied");

endmodule
`default_nettype wire

@@ tb/rv64_execute_stage_with_forwarding_tb.sv @@
// Self-checking testbench of the RV64IM execute stage with operand forwarding.
`timescale 1ns / 100ps
`default_nettype none
module rv64_execute_stage_with_forwarding_tb;
    import rv64_exe_pkg::*;

    // One decoded instruction as it travels on s_tdata, lowest field first.
    typedef struct packed {
        logic [4:0]  cmd;
        logic [4:0]  rs_index;
        logic [4:0]  rt_index;
        logic [4:0]  dst_index;
        logic [63:0] rs_value;
        logic [63:0] rt_value;
        logic [31:0] imm;
        logic [31:0] pc;
        logic        use_imm;
        logic        reg_write;
        logic        mem_to_reg;
        logic [63:0] load_data;
    } instr_s;

    // One execute result as it travels on m_tdata, lowest field first.
    typedef struct packed {
        logic [63:0] alu_out;
        logic [31:0] target_pc;
        logic        redirect;
        logic [63:0] store_data;
        logic [4:0]  dst_out;
        logic        write_out;
        logic        from_mem_out;
    } exec_s;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int RANDOM_ITEMS    = 750;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    rv64_execute_stage_with_forwarding dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // The testbench's own copy of the forwarding window.
    logic [4:0]  fw_near_dst, fw_far_dst;
    logic        fw_near_wr, fw_far_wr, fw_near_mem, fw_far_mem;
    logic [63:0] fw_near_val, fw_far_val;

    exec_s pending_results[$];
    int    error_count;
    int    idle_cycles;
    int    stall_left;

    function automatic logic [IN_BITS-1:0] pack_instr(instr_s t);
        // The 280-bit bus has one zero pad bit at the top.
        return {1'b0, t.load_data, t.mem_to_reg, t.reg_write, t.use_imm, t.pc,
                t.imm, t.rt_value, t.rs_value, t.dst_index, t.rt_index,
                t.rs_index, t.cmd};
    endfunction

    function automatic exec_s unpack_result(logic [OUT_BITS-1:0] d);
        exec_s r;
        r.alu_out      = d[63:0];
        r.target_pc    = d[95:64];
        r.redirect     = d[96];
        r.store_data   = d[160:97];
        r.dst_out      = d[165:161];
        r.write_out    = d[166];
        r.from_mem_out = d[167];
        return r;
    endfunction

    function automatic logic [63:0] sext_word(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Signed division with the RISC-V rules for a zero divisor and overflow.
    function automatic logic [63:0] divide_rv(logic [63:0] a, logic [63:0] b, bit want_rem);
        logic signed [63:0] sa, sb;
        sa = a;
        sb = b;
        if (b == 64'd0) return want_rem ? a : '1;
        if (a == 64'h8000_0000_0000_0000 && b == '1) return want_rem ? 64'd0 : a;
        return want_rem ? sa % sb : sa / sb;
    endfunction

    // Computes the result of one instruction and shifts the forwarding window.
    function automatic exec_s execute_instr(instr_s t);
        exec_s r;
        logic [63:0] rs, rt, a, b, imm64, res, far_fwd;
        logic [31:0] target;
        logic        taken, redirect;
        logic signed [127:0] prod;
        rs = t.rs_value;
        rt = t.rt_value;
        imm64 = {{32{t.imm[31]}}, t.imm};
        res = 64'd0;
        target = t.pc;
        redirect = 1'b0;
        taken = 1'b0;
        // Far slot first, then the near slot overrides it unless it is a load.
        if (fw_far_wr && fw_far_dst != 5'd0) begin
            far_fwd = fw_far_mem ? t.load_data : fw_far_val;
            if (fw_far_dst == t.rs_index) rs = far_fwd;
            if (fw_far_dst == t.rt_index) rt = far_fwd;
        end
        if (fw_near_wr && fw_near_dst != 5'd0 && !fw_near_mem) begin
            if (fw_near_dst == t.rs_index) rs = fw_near_val;
            if (fw_near_dst == t.rt_index) rt = fw_near_val;
        end
        a = rs;
        b = t.use_imm ? imm64 : rt;
        case (cmd_t'(t.cmd))
            CMD_ADD, CMD_LOAD, CMD_STORE: res = a + b;
            CMD_SUB:  res = a - b;
            CMD_MUL:  res = a * b;
            CMD_MULH: begin
                prod = $signed(a) * $signed(b);
                res = prod[127:64];
            end
            CMD_DIV:  res = divide_rv(a, b, 1'b0);
            CMD_REM:  res = divide_rv(a, b, 1'b1);
            CMD_SLL:  res = a << b[5:0];
            CMD_SRL:  res = a >> b[5:0];
            CMD_SRA:  res = $signed(a) >>> b[5:0];
            CMD_SLT:  res = {63'd0, $signed(a) < $signed(b)};
            CMD_XOR:  res = a ^ b;
            CMD_OR:   res = a | b;
            CMD_AND:  res = a & b;
            CMD_ADDW: res = sext_word(a + b);
            CMD_SUBW: res = sext_word(a - b);
            CMD_MULW: res = sext_word({32'd0, a[31:0]} * {32'd0, b[31:0]});
            CMD_SLLW: res = sext_word({32'd0, a[31:0]} << b[4:0]);
            CMD_SRLW: res = sext_word({32'd0, a[31:0]} >> b[4:0]);
            CMD_SRAW: res = sext_word(64'($signed(a[31:0]) >>> b[4:0]));
            CMD_LUI:  res = sext_word({t.imm, 12'd0});
            CMD_AUIPC: res = {32'd0, t.pc} + sext_word({t.imm, 12'd0});
            CMD_JAL: begin
                res = {32'd0, t.pc} + 64'd4;
                target = t.pc + t.imm;
                redirect = 1'b1;
            end
            CMD_JALR: begin
                res = {32'd0, t.pc} + 64'd4;
                target = (rs[31:0] + t.imm) & 32'hFFFF_FFFE;
                redirect = 1'b1;
            end
            CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGE: begin
                case (cmd_t'(t.cmd))
                    CMD_BEQ: taken = (a == b);
                    CMD_BNE: taken = (a != b);
                    CMD_BLT: taken = $signed(a) < $signed(b);
                    default: taken = !($signed(a) < $signed(b));
                endcase
                target = t.pc + t.imm;
                redirect = taken;
            end
            default: ;
        endcase
        r.alu_out = res;
        r.target_pc = target;
        r.redirect = redirect;
        r.store_data = rt;
        r.dst_out = t.dst_index;
        r.write_out = t.reg_write;
        r.from_mem_out = t.mem_to_reg;
        fw_far_dst = fw_near_dst;
        fw_far_wr = fw_near_wr;
        fw_far_mem = fw_near_mem;
        fw_far_val = fw_near_val;
        fw_near_dst = t.dst_index;
        fw_near_wr = t.reg_write;
        fw_near_mem = t.mem_to_reg;
        fw_near_val = res;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h7FFF_FFFF_FFFF_FFFF;
            4: v = 64'($urandom_range(0, 70));
            default: ;
        endcase
        return v;
    endfunction

    function automatic instr_s random_instr();
        instr_s t;
        t.cmd = 5'($urandom_range(0, 31));
        // Small register numbers make forwarding hits common.
        t.rs_index = 5'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4)
                                                     : $urandom_range(0, 31));
        t.rt_index = 5'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4)
                                                     : $urandom_range(0, 31));
        t.dst_index = 5'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4)
                                                      : $urandom_range(0, 31));
        t.rs_value = rand64();
        t.rt_value = ($urandom_range(0, 9) == 0) ? t.rs_value : rand64();
        t.imm = ($urandom_range(0, 2) == 0) ? 32'($signed($urandom_range(0, 80)) - 40) : $urandom;
        t.pc = $urandom;
        t.use_imm = 1'($urandom_range(0, 1));
        t.reg_write = ($urandom_range(0, 4) != 0);
        t.mem_to_reg = (cmd_t'(t.cmd) == CMD_LOAD) ? 1'b1 : ($urandom_range(0, 7) == 0);
        t.load_data = rand64();
        return t;
    endfunction

    function automatic int gap_cycles();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Offers one instruction and records its expected result at acceptance.
    // Valid stays high across back-to-back transactions and drops only for a gap.
    task automatic send_instr(instr_s t, bit has_golden, exec_s golden);
        exec_s predicted;
        int gap;
        gap = gap_cycles();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= pack_instr(t);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = execute_instr(t);
        if (has_golden && predicted != golden) begin
            $display("%0t: directed row disagrees with prediction: expected %p actual %p",
                     $time, golden, predicted);
            error_count++;
        end
        pending_results.push_back(predicted);
    endtask

    // Receiver side: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        exec_s got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual %p", $time, got);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.alu_out !== want.alu_out)
                        $display("%0t: alu_out expected %h actual %h", $time,
                                 want.alu_out, got.alu_out);
                    if (got.target_pc !== want.target_pc)
                        $display("%0t: target_pc expected %h actual %h", $time,
                                 want.target_pc, got.target_pc);
                    if (got.redirect !== want.redirect)
                        $display("%0t: redirect expected %b actual %b", $time,
                                 want.redirect, got.redirect);
                    if (got.store_data !== want.store_data)
                        $display("%0t: store_data expected %h actual %h", $time,
                                 want.store_data, got.store_data);
                    if (got.dst_out !== want.dst_out)
                        $display("%0t: dst_out expected %0d actual %0d", $time,
                                 want.dst_out, got.dst_out);
                    if (got.write_out !== want.write_out)
                        $display("%0t: write_out expected %b actual %b", $time,
                                 want.write_out, got.write_out);
                    if (got.from_mem_out !== want.from_mem_out)
                        $display("%0t: from_mem_out expected %b actual %b", $time,
                                 want.from_mem_out, got.from_mem_out);
                    if (got !== want) error_count++;
                end
            end
            // Mostly ready, with short gaps and now and then a long stall.
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 49) == 0) begin
                m_tready <= 1'b0;
                stall_left <= $urandom_range(10, 80);
            end else begin
                case ($urandom_range(0, 19))
                    0: m_tready <= 1'b0;
                    1, 2, 3: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 29) != 0) ||
                                         ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    // Watchdog: cycles in which no transaction completes on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Directed rows: expected result typed in where it is obvious.
    instr_s directed_rows[$];
    bit     directed_has_golden[$];
    exec_s  directed_golden[$];

    task automatic add_row(instr_s t, bit has_golden, exec_s g);
        directed_rows.push_back(t);
        directed_has_golden.push_back(has_golden);
        directed_golden.push_back(g);
    endtask

    function automatic instr_s mk(logic [4:0] cmd, logic [4:0] rsi, logic [4:0] rti,
                                  logic [4:0] dst, logic [63:0] rs, logic [63:0] rt,
                                  logic [31:0] imm, logic [31:0] pc, logic ui,
                                  logic wr, logic fm, logic [63:0] ld);
        instr_s t;
        t.cmd = cmd; t.rs_index = rsi; t.rt_index = rti; t.dst_index = dst;
        t.rs_value = rs; t.rt_value = rt; t.imm = imm; t.pc = pc; t.use_imm = ui;
        t.reg_write = wr; t.mem_to_reg = fm; t.load_data = ld;
        return t;
    endfunction

    function automatic exec_s mkres(logic [63:0] alu, logic [31:0] tpc, logic rd,
                                    logic [63:0] sd, logic [4:0] dst, logic wr, logic fm);
        exec_s r;
        r.alu_out = alu; r.target_pc = tpc; r.redirect = rd; r.store_data = sd;
        r.dst_out = dst; r.write_out = wr; r.from_mem_out = fm;
        return r;
    endfunction

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

    initial begin
        exec_s none;
        instr_s t;
        int n;
        none = mkres(0, 0, 0, 0, 0, 0, 0);
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        error_count = 0;
        fw_near_dst = 0; fw_near_wr = 0; fw_near_mem = 0; fw_near_val = 0;
        fw_far_dst = 0; fw_far_wr = 0; fw_far_mem = 0; fw_far_val = 0;

        // Right after reset the window is empty, so nothing forwards.
        add_row(mk(CMD_ADD, 1, 2, 0, 64'd5, 64'd7, 0, 32'h100, 0, 0, 0, 0), 1,
                mkres(64'd12, 32'h100, 0, 64'd7, 0, 0, 0));
        add_row(mk(CMD_NOP, 31, 31, 31, '1, '1, '1, '1, 1, 1, 1, '1), 1,
                mkres(0, '1, 0, '1, 31, 1, 1));
        add_row(mk(CMD_DIV, 0, 0, 0, MIN64, 0, 0, 0, 0, 0, 0, 0), 1,
                mkres('1, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_REM, 0, 0, 0, MIN64, 0, 0, 0, 0, 0, 0, 0), 1,
                mkres(MIN64, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_DIV, 0, 0, 0, MIN64, '1, 0, 0, 0, 0, 0, 0), 1,
                mkres(MIN64, 0, 0, '1, 0, 0, 0));
        add_row(mk(CMD_REM, 0, 0, 0, MIN64, '1, 0, 0, 0, 0, 0, 0), 1,
                mkres(0, 0, 0, '1, 0, 0, 0));
        add_row(mk(CMD_MULH, 0, 0, 0, MIN64, MIN64, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(CMD_MUL, 0, 0, 0, MAX64, MAX64, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(CMD_MULW, 0, 0, 0, '1, '1, 0, 0, 0, 0, 0, 0), 0, none);
        // Shift amounts above the mask width must wrap.
        add_row(mk(CMD_SLL, 0, 0, 0, 64'd1, 64'd65, 0, 0, 0, 0, 0, 0), 1,
                mkres(64'd2, 0, 0, 64'd65, 0, 0, 0));
        add_row(mk(CMD_SRAW, 0, 0, 0, 64'h8000_0000, 64'd63, 0, 0, 0, 0, 0, 0), 1,
                mkres('1, 0, 0, 64'd63, 0, 0, 0));
        add_row(mk(CMD_SLT, 0, 0, 0, MIN64, MAX64, 0, 0, 0, 0, 0, 0), 1,
                mkres(64'd1, 0, 0, MAX64, 0, 0, 0));
        add_row(mk(CMD_LUI, 0, 0, 0, 0, 0, 32'h0008_0000, 0, 1, 0, 0, 0), 1,
                mkres(64'hFFFF_FFFF_8000_0000, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_AUIPC, 0, 0, 0, 0, 0, 32'h1, 32'hFFFF_F000, 1, 0, 0, 0), 0, none);
        // Jumps link pc+4 and wrap the target at 32 bits.
        add_row(mk(CMD_JAL, 0, 0, 1, 0, 0, 32'd8, 32'hFFFF_FFFC, 1, 1, 0, 0), 1,
                mkres(64'h1_0000_0000, 32'd4, 1, 0, 1, 1, 0));
        // Near slot forwards x1 into rs of jalr.
        add_row(mk(CMD_JALR, 1, 0, 2, 0, 0, 32'd1, 32'h20, 1, 1, 0, 0), 0, none);
        // Load into x3, then a consumer one later (no near forward of a load).
        add_row(mk(CMD_LOAD, 2, 0, 3, 0, 0, 32'd16, 0, 1, 1, 1, 0), 0, none);
        add_row(mk(CMD_ADD, 3, 3, 4, 64'd9, 64'd9, 0, 0, 0, 1, 0, 0), 0, none);
        // Two behind the load: load_data is forwarded from the far slot.
        add_row(mk(CMD_STORE, 4, 3, 0, 0, 0, 32'd8, 0, 1, 0, 0, 64'hDEAD_BEEF_0BAD_F00D),
                0, none);
        add_row(mk(CMD_BEQ, 0, 0, 0, 64'd3, 64'd3, 32'hFFFF_FFF0, 32'h40, 0, 0, 0, 0), 1,
                mkres(0, 32'h30, 1, 64'd3, 0, 0, 0));
        add_row(mk(CMD_BNE, 0, 0, 0, 64'd3, 64'd3, 32'd16, 32'h40, 0, 0, 0, 0), 1,
                mkres(0, 32'h50, 0, 64'd3, 0, 0, 0));
        add_row(mk(CMD_BLT, 0, 0, 0, MIN64, 0, 32'd4, 0, 1, 0, 0, 0), 0, none);
        add_row(mk(CMD_BGE, 0, 0, 0, MAX64, MIN64, 32'd4, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(CMD_RSV1, 0, 0, 0, '1, 0, 0, 32'h77, 0, 0, 0, 0), 1,
                mkres(0, 32'h77, 0, 0, 0, 0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_instr(directed_rows[i], directed_has_golden[i], directed_golden[i]);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            t = random_instr();
            send_instr(t, 0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && !m_tvalid) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
